// File: hdl/frp_pkg.sv
// ----------------------------------------------------------------------------
// Firmata receive parser package
// Shared types, command codes and layout constants for the receive parser.
// ----------------------------------------------------------------------------
package frp_pkg;

    localparam int RX_W          = 8;
    localparam int CHAN_W        = 4;
    localparam int VALUE_W       = 14;
    localparam int DATA7_W       = 7;
    localparam int PORT_BITS     = 8;
    localparam int NUM_PINS      = 24;
    localparam int NUM_ANALOG    = 16;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 24;
    localparam int M_TDATA_W     = 32;
    localparam int M_TUSER_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NEW_PIN_LAYOUT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_PIN_MASK = 1'd1;

    // Command codes (upper nibble for channel commands, full byte otherwise)
    localparam logic [3:0]      CMD_NIB_DIGITAL = 4'h9;
    localparam logic [3:0]      CMD_NIB_ANALOG  = 4'hE;
    localparam logic [RX_W-1:0] CMD_SYSEX_START = 8'hF0;
    localparam logic [RX_W-1:0] CMD_SYSEX_END   = 8'hF7;
    localparam logic [RX_W-1:0] CMD_VERSION     = 8'hF9;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_DIGITAL    = 3'd1,
        EV_ANALOG     = 3'd2,
        EV_VERSION    = 3'd3,
        EV_SYSEX_BYTE = 3'd4,
        EV_SYSEX_END  = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_DIGITAL = 2'd1,
        PEND_ANALOG  = 2'd2,
        PEND_VERSION = 2'd3
    } pend_t;

    // Port bits that map onto physical pins, by port number and layout.
    function automatic logic [PORT_BITS-1:0] port_bit_mask(input logic [CHAN_W-1:0] port,
                                                           input logic new_layout);
        logic [PORT_BITS-1:0] mask;
        mask = '0;
        case (port)
            4'd0:    mask = 8'hFC;
            4'd1:    mask = new_layout ? 8'hFF : 8'h3F;
            4'd2:    mask = new_layout ? 8'h0F : 8'h3F;
            default: mask = '0;
        endcase
        return mask;
    endfunction

endpackage

// File: hdl/firmata_receive_parser.sv
// ----------------------------------------------------------------------------
// Firmata receive parser
// Turns a stream of received Firmata bytes into one decoded result per byte.
// ----------------------------------------------------------------------------
// One byte is accepted every clock cycle unless back-pressure holds the input,
// and each byte gives exactly one result transaction. A byte is held in an
// input register, decoded in a single pass against the parser state, and its
// result is written to the output register at the clock edge where the result
// side can take it; the parser state is updated at that same edge, so the next
// byte sees it without any bubble. Back-pressure on the result side stalls the
// input side only once both registers are full. Configuration writes take
// effect on the next clock edge and should only be made while no bytes are in
// flight.
module firmata_receive_parser
    import frp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // Received byte stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [RX_W-1:0]        s_tdata,    // [7:0] rx_byte
    // Decoded result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // [3:0] channel, [17:4] value,
                                               // [25:18] changed_pins,
                                               // [26] analog_changed, rest zero
    output logic [M_TUSER_W-1:0]   m_tuser     // [2:0] event_res
);

    // Configuration registers
    logic                     new_layout_reg;
    logic [NUM_PINS-1:0]      input_mask_reg;

    // Input stage
    logic                     in_valid_reg;
    logic [RX_W-1:0]          in_byte_reg;

    // Parser state
    logic [1:0]               awaited_reg, awaited_next;
    logic                     in_sysex_reg, in_sysex_next;
    pend_t                    pend_reg, pend_next;
    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic [DATA7_W-1:0]       first_byte_reg, first_byte_next;
    logic [VALUE_W-1:0]       analog_last_reg [NUM_ANALOG];
    logic [NUM_ANALOG-1:0]    analog_seen_reg, analog_seen_next;
    logic [NUM_PINS-1:0]      pin_last_reg, pin_last_next;
    logic [NUM_PINS-1:0]      pin_seen_reg, pin_seen_next;

    // Result stage
    logic                     out_valid_reg;
    event_t                   out_event_reg, out_event_next;
    logic [CHAN_W-1:0]        out_chan_reg, out_chan_next;
    logic [VALUE_W-1:0]       out_value_reg, out_value_next;
    logic [PORT_BITS-1:0]     out_chg_reg, out_chg_next;
    logic                     out_ach_reg, out_ach_next;

    logic                     advance;
    logic                     analog_wr;
    logic                     digital_upd;
    logic [VALUE_W-1:0]       assembled;
    logic [PORT_BITS-1:0]     port_mask;
    logic [NUM_PINS-1:0]      pin_chg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {5'b0, out_ach_reg, out_chg_reg, out_value_reg, out_chan_reg};

    assign assembled = {in_byte_reg[DATA7_W-1:0], first_byte_reg};
    assign port_mask = port_bit_mask(chan_reg, new_layout_reg);

    // Decode of one byte against the current state.
    always_comb begin
        awaited_next    = awaited_reg;
        in_sysex_next   = in_sysex_reg;
        pend_next       = pend_reg;
        chan_next       = chan_reg;
        first_byte_next = first_byte_reg;
        out_event_next  = EV_NONE;
        out_chan_next   = '0;
        out_value_next  = '0;
        out_ach_next    = 1'b0;
        analog_wr       = 1'b0;
        digital_upd     = 1'b0;

        if (in_sysex_reg) begin
            if (in_byte_reg == CMD_SYSEX_END) begin
                in_sysex_next  = 1'b0;
                awaited_next   = '0;
                out_event_next = EV_SYSEX_END;
            end else begin
                out_event_next = EV_SYSEX_BYTE;
                out_value_next = VALUE_W'(in_byte_reg);
            end
        end else if (awaited_reg != 2'd0 && !in_byte_reg[RX_W-1]) begin
            awaited_next = awaited_reg - 2'd1;
            if (awaited_next == 2'd1) begin
                first_byte_next = in_byte_reg[DATA7_W-1:0];
            end else if (awaited_next == 2'd0) begin
                case (pend_reg)
                    PEND_DIGITAL: begin
                        out_event_next = EV_DIGITAL;
                        out_chan_next  = chan_reg;
                        out_value_next = assembled;
                        digital_upd    = 1'b1;
                    end
                    PEND_ANALOG: begin
                        out_event_next = EV_ANALOG;
                        out_chan_next  = chan_reg;
                        out_value_next = assembled;
                        out_ach_next   = analog_seen_reg[chan_reg] &&
                                         (analog_last_reg[chan_reg] != assembled);
                        analog_wr      = 1'b1;
                    end
                    PEND_VERSION: begin
                        out_event_next = EV_VERSION;
                        out_value_next = assembled;
                    end
                    default: begin
                        out_event_next = EV_NONE;
                    end
                endcase
            end
        end else begin
            // Command byte, or a data byte nobody is waiting for.
            if (in_byte_reg < CMD_SYSEX_START) begin
                chan_next = in_byte_reg[CHAN_W-1:0];
                if (in_byte_reg[RX_W-1:CHAN_W] == CMD_NIB_DIGITAL) begin
                    awaited_next = 2'd2;
                    pend_next    = PEND_DIGITAL;
                end else if (in_byte_reg[RX_W-1:CHAN_W] == CMD_NIB_ANALOG) begin
                    awaited_next = 2'd2;
                    pend_next    = PEND_ANALOG;
                end
            end else if (in_byte_reg == CMD_VERSION) begin
                awaited_next = 2'd2;
                pend_next    = PEND_VERSION;
            end else if (in_byte_reg == CMD_SYSEX_START) begin
                awaited_next  = '0;
                in_sysex_next = 1'b1;
            end
        end
    end

    // Per-pin change detection; each pin belongs to a fixed port and port bit.
    always_comb begin
        logic [4:0] pin_idx;
        logic       active;
        logic       level;
        pin_last_next = pin_last_reg;
        pin_seen_next = pin_seen_reg;
        pin_chg       = '0;
        for (int p = 0; p < NUM_PINS; p++) begin
            pin_idx = 5'(p);
            level   = assembled[pin_idx[2:0]];
            active  = digital_upd && (chan_reg == CHAN_W'(pin_idx[4:3])) &&
                      port_mask[pin_idx[2:0]] && input_mask_reg[p];
            if (active) begin
                pin_chg[p]       = !pin_seen_reg[p] || (pin_last_reg[p] != level);
                pin_last_next[p] = level;
                pin_seen_next[p] = 1'b1;
            end
        end
        case (chan_reg)
            4'd0:    out_chg_next = pin_chg[7:0];
            4'd1:    out_chg_next = pin_chg[15:8];
            4'd2:    out_chg_next = pin_chg[23:16];
            default: out_chg_next = '0;
        endcase
    end

    always_comb begin
        analog_seen_next = analog_seen_reg;
        if (analog_wr) begin
            analog_seen_next[chan_reg] = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            new_layout_reg  <= 1'b1;
            input_mask_reg  <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            awaited_reg     <= '0;
            in_sysex_reg    <= 1'b0;
            pend_reg        <= PEND_NONE;
            chan_reg        <= '0;
            first_byte_reg  <= '0;
            analog_seen_reg <= '0;
            pin_seen_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_NEW_PIN_LAYOUT) begin
                    new_layout_reg <= cfg_wr_data[0];
                end else if (cfg_index == REG_INPUT_PIN_MASK) begin
                    input_mask_reg <= cfg_wr_data[NUM_PINS-1:0];
                end
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                awaited_reg     <= awaited_next;
                in_sysex_reg    <= in_sysex_next;
                pend_reg        <= pend_next;
                chan_reg        <= chan_next;
                first_byte_reg  <= first_byte_next;
                analog_seen_reg <= analog_seen_next;
                pin_seen_reg    <= pin_seen_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_event_reg <= out_event_next;
            out_chan_reg  <= out_chan_next;
            out_value_reg <= out_value_next;
            out_chg_reg   <= out_chg_next;
            out_ach_reg   <= out_ach_next;
            pin_last_reg  <= pin_last_next;
            if (analog_wr) begin
                analog_last_reg[chan_reg] <= assembled;
            end
        end
    end

endmodule

// File: hdl/frp_checker.sv
// ----------------------------------------------------------------------------
// Firmata receive parser checker
// Port-level checks on the result stream, bound to the parser top level.
// ----------------------------------------------------------------------------
module frp_checker
    import frp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result transaction must hold its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Changed-pin bits only accompany digital port events.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != EV_DIGITAL) |-> (m_tdata[25:18] == '0))
        else $error("changed_pins set on a non-digital event");

    // The analog change flag only accompanies analog samples.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != EV_ANALOG) |-> !m_tdata[26])
        else $error("analog_changed set on a non-analog event");

    // A channel is only reported with digital and analog events.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != EV_DIGITAL) && (m_tuser != EV_ANALOG)
            |-> (m_tdata[3:0] == '0))
        else $error("channel reported on an event without one");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind firmata_receive_parser frp_checker u_frp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
